// ===== rtl/core/cbe_pkg.sv =====
// cbe_pkg: shared widths, register indexes and fragment type for the
// cidr block exclude core; no dependencies
package cbe_pkg;

  localparam int ADDR_W    = 32;
  localparam int PFX_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [PFX_W-1:0] PFX_MAX = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_PREFIX = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PFX_W-1:0]  prefix;
    logic              last;
  } frag_t;

  function automatic logic [PFX_W-1:0] sat_prefix(input logic [PFX_W-1:0] p);
    return (p > PFX_MAX) ? PFX_MAX : p;
  endfunction

endpackage

// ===== rtl/core/cbe_walk.sv =====
// cbe_walk: bit-serial walker, msb first, one prefix level per cycle
// unless a fragment waits on can_push; depends on cbe_pkg
module cbe_walk import cbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] in_block_addr,
  input  logic [PFX_W-1:0]  in_block_prefix,
  input  logic [ADDR_W-1:0] excl_addr,
  input  logic [PFX_W-1:0]  excl_prefix,
  input  logic              can_push,
  output logic              push,
  output frag_t             frag
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic              state_r, state_nxt;
  logic [ADDR_W-1:0] blk_sh_r, blk_sh_nxt;
  logic [ADDR_W-1:0] exc_sh_r, exc_sh_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] held_r, held_nxt;
  logic [ADDR_W-1:0] eacc_r, eacc_nxt;
  logic [PFX_W-1:0]  bp_r, bp_nxt;
  logic [PFX_W-1:0]  ep_r, ep_nxt;
  logic [PFX_W-1:0]  lvl_r, lvl_nxt;
  logic              mism_r, mism_nxt;
  logic              b_bit;
  logic              e_bit;

  assign b_bit    = blk_sh_r[ADDR_W-1];
  assign e_bit    = exc_sh_r[ADDR_W-1];
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    blk_sh_nxt = blk_sh_r;
    exc_sh_nxt = exc_sh_r;
    pos_nxt    = pos_r;
    held_nxt   = held_r;
    eacc_nxt   = eacc_r;
    bp_nxt     = bp_r;
    ep_nxt     = ep_r;
    lvl_nxt    = lvl_r;
    mism_nxt   = mism_r;
    push       = 1'b0;
    frag       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          blk_sh_nxt = in_block_addr;
          exc_sh_nxt = excl_addr;
          bp_nxt     = sat_prefix(in_block_prefix);
          ep_nxt     = sat_prefix(excl_prefix);
          lvl_nxt    = 6'd1;
          pos_nxt    = {1'b1, {(ADDR_W-1){1'b0}}};
          held_nxt   = '0;
          eacc_nxt   = '0;
          mism_nxt   = 1'b0;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (lvl_r <= bp_r) begin
          // prefix levels of the request: gather bits and compare
          held_nxt   = held_r | (pos_r & {ADDR_W{b_bit}});
          eacc_nxt   = eacc_r | (pos_r & {ADDR_W{e_bit}});
          mism_nxt   = mism_r | ((lvl_r <= ep_r) & (b_bit ^ e_bit));
          blk_sh_nxt = {blk_sh_r[ADDR_W-2:0], 1'b0};
          exc_sh_nxt = {exc_sh_r[ADDR_W-2:0], 1'b0};
          pos_nxt    = {1'b0, pos_r[ADDR_W-1:1]};
          lvl_nxt    = lvl_r + 6'd1;
        end else if (mism_r) begin
          // disjoint: pass the cleared block through
          frag.addr   = held_r;
          frag.prefix = bp_r;
          frag.last   = 1'b1;
          if (can_push) begin
            push      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (ep_r <= bp_r) begin
          state_nxt = ST_IDLE;
        end else begin
          // sibling half at this level
          frag.addr   = eacc_r | (pos_r & {ADDR_W{~e_bit}});
          frag.prefix = lvl_r;
          frag.last   = (lvl_r == ep_r);
          if (can_push) begin
            push       = 1'b1;
            eacc_nxt   = eacc_r | (pos_r & {ADDR_W{e_bit}});
            exc_sh_nxt = {exc_sh_r[ADDR_W-2:0], 1'b0};
            pos_nxt    = {1'b0, pos_r[ADDR_W-1:1]};
            lvl_nxt    = lvl_r + 6'd1;
            if (lvl_r == ep_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_sh_r <= blk_sh_nxt;
    exc_sh_r <= exc_sh_nxt;
    pos_r    <= pos_nxt;
    held_r   <= held_nxt;
    eacc_r   <= eacc_nxt;
    bp_r     <= bp_nxt;
    ep_r     <= ep_nxt;
    lvl_r    <= lvl_nxt;
    mism_r   <= mism_nxt;
  end

endmodule

// ===== rtl/core/cbe_out_stage.sv =====
// cbe_out_stage: output register between the walker and the result channel
// depends on cbe_pkg
module cbe_out_stage import cbe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  frag_t             frag,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_frag_addr,
  output logic [PFX_W-1:0]  out_frag_prefix,
  output logic              out_frag_last
);

  logic  valid_r, valid_nxt;
  frag_t data_r;

  assign can_push = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= frag;
    end
  end

  assign out_valid       = valid_r;
  assign out_frag_addr   = data_r.addr;
  assign out_frag_prefix = data_r.prefix;
  assign out_frag_last   = data_r.last;

endmodule

// ===== rtl/core/cidr_block_exclude_core.sv =====
// cidr_block_exclude_core: subtracts the configured exclusion block from each
// request, one address bit per cycle while fragments are not stalled; one
// request in flight at a time. Steps: accept the request, walk each prefix
// level of the request, then emit the fragments.
// throughput set by the single bit-serial walker; the output register frees it.
// reset: synchronous active-low rst_n; excl_addr 0, excl_prefix 32, idle.
module cidr_block_exclude_core import cbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_W-1:0]    in_block_addr,
  input  logic [PFX_W-1:0]     in_block_prefix,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_W-1:0]    out_frag_addr,
  output logic [PFX_W-1:0]     out_frag_prefix,
  output logic                 out_frag_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0] excl_addr_r;
  logic [PFX_W-1:0]  excl_prefix_r;
  logic              can_push;
  logic              push;
  frag_t             frag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_addr_r   <= '0;
      excl_prefix_r <= PFX_MAX;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_EXCL_ADDR) begin
        excl_addr_r <= cfg_data;
      end
      if (cfg_index == CFG_EXCL_PREFIX) begin
        excl_prefix_r <= cfg_data[PFX_W-1:0];
      end
    end
  end

  cbe_walk u_walk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_block_addr   (in_block_addr),
    .in_block_prefix (in_block_prefix),
    .excl_addr       (excl_addr_r),
    .excl_prefix     (excl_prefix_r),
    .can_push        (can_push),
    .push            (push),
    .frag            (frag)
  );

  cbe_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .frag            (frag),
    .can_push        (can_push),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frag_addr   (out_frag_addr),
    .out_frag_prefix (out_frag_prefix),
    .out_frag_last   (out_frag_last)
  );

`ifndef ASSERT_OFF
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("walker idle right after a request");

  a_frag_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frag_prefix <= PFX_MAX)
    else $error("fragment prefix beyond 32");

  a_cfg_prefix_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == CFG_EXCL_PREFIX
      |=> excl_prefix_r == $past(cfg_data[PFX_W-1:0]))
    else $error("exclusion prefix write lost");
`endif

endmodule
